// ----- rtl/core/balu_pkg.sv -----
// Package for the byte ALU with status flags.
// Holds the operation codes, status flag positions, BCD correction constants
// and the beat types shared by the pipeline stages. No dependencies.
package balu_pkg;

	typedef enum logic [3:0] {
		OP_ADC  = 4'd0,
		OP_SBC  = 4'd1,
		OP_INC  = 4'd2,
		OP_DEC  = 4'd3,
		OP_AND  = 4'd4,
		OP_OR   = 4'd5,
		OP_EOR  = 4'd6,
		OP_ROL  = 4'd7,
		OP_ROR  = 4'd8,
		OP_ASL  = 4'd9,
		OP_LSR  = 4'd10,
		OP_BIT  = 4'd11,
		OP_CMP  = 4'd12,
		OP_LOAD = 4'd13
	} op_t;

	// Status bit positions
	localparam logic [2:0] FlagC = 3'd0;
	localparam logic [2:0] FlagZ = 3'd1;
	localparam logic [2:0] FlagD = 3'd3;
	localparam logic [2:0] FlagV = 3'd6;
	localparam logic [2:0] FlagN = 3'd7;

	// Decimal correction
	localparam logic [7:0] BcdLoFix = 8'h06;
	localparam logic [7:0] BcdHiFix = 8'h60;
	localparam logic [4:0] BcdDigitMax = 5'd9;

	typedef struct packed {
		logic [3:0] cmd;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [7:0] status_in;
	} op_beat_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic [7:0] status_out;
	} res_beat_t;

endpackage

// ----- rtl/core/balu_op_if.sv -----
// Operand channel: valid/ready handshake with the operation beat fields.
// Standalone; no package dependency.
interface balu_op_if;
	logic       valid;
	logic       ready;
	logic [3:0] cmd;
	logic [7:0] operand_a;
	logic [7:0] operand_b;
	logic [7:0] status_in;

	modport source (output valid, output cmd, output operand_a, output operand_b,
		output status_in, input ready);
	modport sink (input valid, input cmd, input operand_a, input operand_b,
		input status_in, output ready);
endinterface

// ----- rtl/core/balu_res_if.sv -----
// Result channel: valid/ready handshake with the result byte and status.
// Standalone; no package dependency.
interface balu_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic [7:0] status_out;

	modport source (output valid, output result_byte, output status_out, input ready);
	modport sink (input valid, input result_byte, input status_out, output ready);
endinterface

// ----- rtl/core/balu_in_stage.sv -----
// Operand register: captures one operation beat per cycle while the next stage keeps taking them.
// Uses balu_pkg and the balu_op_if channel.
module balu_in_stage
	import balu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	balu_op_if.sink       item,
	output logic          link_valid,
	input  logic          link_ready,
	output op_beat_t      beat_s1
);

	logic valid_s1;
	logic take;

	// Refill whenever the register is empty or its beat moves on this cycle
	assign item.ready = !valid_s1 || link_ready;
	assign take       = item.valid && item.ready;
	assign link_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1.cmd       <= item.cmd;
			beat_s1.operand_a <= item.operand_a;
			beat_s1.operand_b <= item.operand_b;
			beat_s1.status_in <= item.status_in;
		end
	end

endmodule

// ----- rtl/core/balu_core.sv -----
// Combinational ALU: result byte and updated status for one operation beat.
// Uses balu_pkg for opcodes, flag positions and BCD constants.
module balu_core
	import balu_pkg::*;
(
	input  op_beat_t  beat,
	output res_beat_t res
);

	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] st_in;
	logic       cin;
	logic       borrow;

	logic [8:0] adc_bin;
	logic [5:0] dlo_raw;
	logic [5:0] dlo;
	logic [9:0] dsum;
	logic [9:0] dsum_fix;
	logic       dadc_v;

	logic [8:0] sbc_bin;
	logic [4:0] dslo;
	logic [4:0] dshi;
	logic [4:0] dslo_adj;
	logic [4:0] dshi_adj;
	logic [4:0] dshi_fix;

	logic [8:0] cmp_diff;
	logic [7:0] r;
	logic [7:0] st;

	assign a      = beat.operand_a;
	assign b      = beat.operand_b;
	assign st_in  = beat.status_in;
	assign cin    = st_in[FlagC];
	assign borrow = ~cin;

	// Binary and decimal add
	assign adc_bin = {1'b0, a} + {1'b0, b} + {8'd0, cin};
	assign dlo_raw = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, cin};
	assign dlo     = (dlo_raw > {1'b0, BcdDigitMax}) ? dlo_raw + BcdLoFix[5:0] : dlo_raw;
	assign dsum    = {2'b00, a[7:4], 4'h0} + {2'b00, b[7:4], 4'h0}
		+ {5'd0, |dlo[5:4], 4'h0} + {6'd0, dlo[3:0]};
	assign dadc_v  = ~(a[7] ^ b[7]) & (a[7] ^ dsum[7]);
	assign dsum_fix = (dsum[8:4] > BcdDigitMax) ? dsum + {2'b00, BcdHiFix} : dsum;

	// Binary and decimal subtract; flags always come from the binary difference
	assign sbc_bin  = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
	assign dslo     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, borrow};
	assign dshi     = {1'b0, a[7:4]} - {1'b0, b[7:4]};
	assign dslo_adj = dslo[4] ? dslo - BcdLoFix[4:0] : dslo;
	assign dshi_adj = dslo[4] ? dshi - 5'd1 : dshi;
	assign dshi_fix = dshi_adj[4] ? dshi_adj - BcdLoFix[4:0] : dshi_adj;

	assign cmp_diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		r  = a;
		st = st_in;
		unique case (op_t'(beat.cmd))
			OP_ADC: begin
				if (st_in[FlagD]) begin
					r         = dsum_fix[7:0];
					st[FlagZ] = (adc_bin[7:0] == 8'h00);
					st[FlagN] = dsum[7];
					st[FlagV] = dadc_v;
					st[FlagC] = |dsum_fix[9:8];
				end else begin
					r         = adc_bin[7:0];
					st[FlagZ] = (adc_bin[7:0] == 8'h00);
					st[FlagN] = adc_bin[7];
					st[FlagC] = adc_bin[8];
					st[FlagV] = (a[7] ^ adc_bin[7]) & (b[7] ^ adc_bin[7]);
				end
			end
			OP_SBC: begin
				r         = st_in[FlagD] ? {dshi_fix[3:0], dslo_adj[3:0]} : sbc_bin[7:0];
				st[FlagZ] = (sbc_bin[7:0] == 8'h00);
				st[FlagN] = sbc_bin[7];
				st[FlagC] = ~sbc_bin[8];
				st[FlagV] = (a[7] ^ b[7]) & (a[7] ^ sbc_bin[7]);
			end
			OP_INC: begin
				r         = a + 8'd1;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
			end
			OP_DEC: begin
				r         = a - 8'd1;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
			end
			OP_AND: begin
				r         = a & b;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
			end
			OP_OR: begin
				r         = a | b;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
			end
			OP_EOR: begin
				r         = a ^ b;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
			end
			OP_ROL: begin
				r         = {a[6:0], cin};
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
				st[FlagC] = a[7];
			end
			OP_ROR: begin
				r         = {cin, a[7:1]};
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
				st[FlagC] = a[0];
			end
			OP_ASL: begin
				r         = {a[6:0], 1'b0};
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = r[7];
				st[FlagC] = a[7];
			end
			OP_LSR: begin
				r         = {1'b0, a[7:1]};
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = 1'b0;
				st[FlagC] = a[0];
			end
			OP_BIT: begin
				r         = a & b;
				st[FlagZ] = (r == 8'h00);
				st[FlagN] = b[7];
				st[FlagV] = b[6];
			end
			OP_CMP: begin
				r         = cmp_diff[7:0];
				st[FlagC] = ~cmp_diff[8];
				st[FlagZ] = (a == b);
				st[FlagN] = cmp_diff[7];
			end
			OP_LOAD: begin
				r         = a;
				st[FlagZ] = (a == 8'h00);
				st[FlagN] = a[7];
			end
			default: begin
				// unused codes pass operand and status through
				r  = a;
				st = st_in;
			end
		endcase
	end

	assign res.result_byte = r;
	assign res.status_out  = st;

endmodule

// ----- rtl/core/balu_out_stage.sv -----
// Result register: holds one finished beat until the sink takes it.
// Uses balu_pkg and the balu_res_if channel.
module balu_out_stage
	import balu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          link_valid,
	output logic          link_ready,
	input  res_beat_t     res,
	balu_res_if.source    result
);

	logic      valid_s2;
	res_beat_t beat_s2;

	// Free when empty or the held beat leaves this cycle
	assign link_ready = !valid_s2 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (link_ready) begin
			valid_s2 <= link_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link_ready && link_valid) begin
			beat_s2 <= res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.result_byte = beat_s2.result_byte;
	assign result.status_out  = beat_s2.status_out;

endmodule

// ----- rtl/core/byte_alu_with_status_flags.sv -----
// 8-bit processor ALU with status flags (add/subtract with decimal mode,
// inc/dec, logic ops, shifts and rotates, bit test, compare, load). Each beat
// on the item channel is registered, evaluated by one pass of combinational
// logic and registered again on the result channel: the result becomes valid
// once its beat has moved from the operand register into the result register,
// and one beat is accepted every cycle while the result sink keeps up.
// Throughput is set only by the result register, which frees itself in the
// same cycle its beat is taken. No state is kept between beats; status bits
// an operation does not touch pass through unchanged.
// Depends on balu_pkg, balu_op_if, balu_res_if and the balu_* stage modules.
module byte_alu_with_status_flags
	import balu_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	balu_op_if.sink       item,
	balu_res_if.source    result
);

	logic        link_valid;
	logic        link_ready;
	op_beat_t    beat_s1;
	res_beat_t   res;

	balu_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.beat_s1    (beat_s1)
	);

	balu_core u_core (
		.beat (beat_s1),
		.res  (res)
	);

	balu_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.link_valid (link_valid),
		.link_ready (link_ready),
		.res        (res),
		.result     (result)
	);

endmodule
